// ===== hw/rtl/swc_pkg.sv =====
// ----------------------------------------------------------------------------
// swc_pkg - shared constants for the swirl warp coordinate pipeline
// Fixed-point formats, CORDIC tables and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

    localparam int COORD_BITS    = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    localparam int VW  = 36;   // vectoring datapath, Q.16
    localparam int RW  = 40;   // rotation datapath, Q.16
    localparam int ZW  = 34;   // rotation residual angle
    localparam int CFW = 22;   // config data width
    localparam int OW  = 24;   // output width

    localparam logic [23:0] INV_GAIN     = 24'd10188014;
    localparam logic [25:0] TWIST_TO_BAU = 26'd42722829;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    localparam logic [7:0] REG_CENTER_X   = 8'd0;
    localparam logic [7:0] REG_CENTER_Y   = 8'd1;
    localparam logic [7:0] REG_TWIST_RATE = 8'd2;
    localparam logic [7:0] REG_ZOOM_RECIP = 8'd3;

    localparam logic [31:0] ATAN_BAU [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

`default_nettype wire

// ===== hw/rtl/swirl_warp_coords_top.sv =====
// ----------------------------------------------------------------------------
// swirl_warp_coords_top - swirl warp source coordinate generator
// Registers in order: fold, vectoring CORDIC, scale, rotation CORDIC, output.
// Throughput: one beat per cycle unless stalled; set by fully pipelined CORDICs.
// Output register plus one skid entry: while the output stalls the pipe moves
// until a beat enters the skid entry, then freezes until the skid entry drains.
// Reset: asynchronous, active low; clears valid bits and config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module swirl_warp_coords_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input beats
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [13:0]            dest_x,
    input  wire logic [13:0]            dest_y,
    // result beats
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [23:0]          src_x,
    output logic signed [23:0]          src_y,
    output logic                        clamped,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [7:0]             cfg_index,
    input  wire logic [21:0]            cfg_data
);

    localparam int CB = swc_pkg::COORD_BITS;
    localparam int VW = swc_pkg::VW;
    localparam int RW = swc_pkg::RW;
    localparam int ZW = swc_pkg::ZW;

    // ---------------- configuration registers ----------------
    logic [CB-1:0]      center_x_reg, center_y_reg;
    logic signed [21:0] twist_reg;
    logic [15:0]        zoom_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            twist_reg    <= '0;
            zoom_reg     <= 16'd4096;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                swc_pkg::REG_CENTER_X:   center_x_reg <= cfg_data[CB-1:0];
                swc_pkg::REG_CENTER_Y:   center_y_reg <= cfg_data[CB-1:0];
                swc_pkg::REG_TWIST_RATE: twist_reg    <= $signed(cfg_data);
                swc_pkg::REG_ZOOM_RECIP: zoom_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    // The whole pipe moves whenever the skid entry is free; the skid
    // absorbs the one beat that may leave the pipe while the output stalls.
    logic en;
    logic skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    // ---------------- front: offset and half-plane fold ----------------
    logic signed [CB:0]   dx, dy;
    logic signed [VW-1:0] fx, fy;
    logic                 f_vld_reg;
    logic signed [VW-1:0] fx_reg, fy_reg;
    logic [31:0]          fa_reg;

    assign dx = $signed({1'b0, dest_x[CB-1:0]}) - $signed({1'b0, center_x_reg});
    assign dy = $signed({1'b0, dest_y[CB-1:0]}) - $signed({1'b0, center_y_reg});
    assign fx = VW'(dx) <<< 16;
    assign fy = VW'(dy) <<< 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // left half plane: turn by half a turn first
            if (dx[CB])
            begin
                fx_reg <= -fx;
                fy_reg <= -fy;
                fa_reg <= swc_pkg::HALF_TURN;
            end
            else
            begin
                fx_reg <= fx;
                fy_reg <= fy;
                fa_reg <= '0;
            end
        end
    end

    // ---------------- radius and angle ----------------
    logic                 vec_vld;
    logic signed [VW-1:0] vec_x;
    logic [31:0]          vec_ang;

    swc_vectoring u_vec (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld_reg),
        .x_in    (fx_reg),
        .y_in    (fy_reg),
        .ang_in  (fa_reg),
        .out_vld (vec_vld),
        .x_out   (vec_x),
        .ang_out (vec_ang)
    );

    // ---------------- zoom, twist, rotation start ----------------
    logic                 sc_vld;
    logic signed [RW-1:0] sc_x;
    logic signed [ZW-1:0] sc_z;

    swc_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vec_vld),
        .mag_in  (vec_x),
        .ang_in  (vec_ang),
        .zoom    (zoom_reg),
        .twist   (twist_reg),
        .out_vld (sc_vld),
        .x_out   (sc_x),
        .z_out   (sc_z)
    );

    // ---------------- back to an offset ----------------
    logic                 rot_vld;
    logic signed [RW-1:0] rot_x, rot_y;

    swc_rotation u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sc_vld),
        .x_in    (sc_x),
        .z_in    (sc_z),
        .out_vld (rot_vld),
        .x_out   (rot_x),
        .y_out   (rot_y)
    );

    // ---------------- round to Q.8, re-centre, saturate ----------------
    logic signed [RW:0] sum_x, sum_y;
    logic signed [23:0] fin_x, fin_y;
    logic               hi_x, lo_x, hi_y, lo_y;

    assign sum_x = ((RW+1)'(rot_x) + 128) >>> 8;
    assign sum_y = ((RW+1)'(rot_y) + 128) >>> 8;

    logic signed [RW:0] tot_x, tot_y;
    assign tot_x = sum_x + $signed({{(RW+1-CB-8){1'b0}}, center_x_reg, 8'd0});
    assign tot_y = sum_y + $signed({{(RW+1-CB-8){1'b0}}, center_y_reg, 8'd0});

    assign hi_x = tot_x > $signed((RW+1)'(8388607));
    assign lo_x = tot_x < -$signed((RW+1)'(8388608));
    assign hi_y = tot_y > $signed((RW+1)'(8388607));
    assign lo_y = tot_y < -$signed((RW+1)'(8388608));

    assign fin_x = hi_x ? 24'sh7FFFFF : (lo_x ? -24'sh800000 : tot_x[23:0]);
    assign fin_y = hi_y ? 24'sh7FFFFF : (lo_y ? -24'sh800000 : tot_y[23:0]);

    // ---------------- output register and skid ----------------
    logic               out_vld_reg;
    logic signed [23:0] ox_reg, oy_reg, sx_reg, sy_reg;
    logic               oc_reg, sc_reg;
    logic               o_free;

    assign o_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (o_free)
        begin
            out_vld_reg  <= skid_vld_reg || rot_vld;
            skid_vld_reg <= 1'b0;
        end
        else if (en && rot_vld)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (o_free)
        begin
            if (skid_vld_reg)
            begin
                ox_reg <= sx_reg;
                oy_reg <= sy_reg;
                oc_reg <= sc_reg;
            end
            else
            begin
                ox_reg <= fin_x;
                oy_reg <= fin_y;
                oc_reg <= hi_x || lo_x || hi_y || lo_y;
            end
        end
        else if (en && rot_vld)
        begin
            sx_reg <= fin_x;
            sy_reg <= fin_y;
            sc_reg <= hi_x || lo_x || hi_y || lo_y;
        end
    end

    assign out_valid = out_vld_reg;
    assign src_x     = ox_reg;
    assign src_y     = oy_reg;
    assign clamped   = oc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swc_vectoring.sv =====
// ----------------------------------------------------------------------------
// swc_vectoring - pipelined CORDIC in vectoring mode
// One micro-rotation per register stage; drives y to zero, gathers angle.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_vectoring (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_vld,
    input  wire logic signed [swc_pkg::VW-1:0]  x_in,
    input  wire logic signed [swc_pkg::VW-1:0]  y_in,
    input  wire logic        [31:0]             ang_in,
    output logic                                out_vld,
    output logic signed [swc_pkg::VW-1:0]       x_out,
    output logic        [31:0]                  ang_out
);

    localparam int N = swc_pkg::NSTG;

    logic                          v_reg [N];
    logic signed [swc_pkg::VW-1:0] x_reg [N];
    logic signed [swc_pkg::VW-1:0] y_reg [N];
    logic        [31:0]            a_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic                          vi;
        logic signed [swc_pkg::VW-1:0] xi;
        logic signed [swc_pkg::VW-1:0] yi;
        logic        [31:0]            ai;
        logic signed [swc_pkg::VW-1:0] xs;
        logic signed [swc_pkg::VW-1:0] ys;
        logic                          ypos;

        if (k == 0) begin : g_first
            assign vi = in_vld;
            assign xi = x_in;
            assign yi = y_in;
            assign ai = ang_in;
        end
        else begin : g_rest
            assign vi = v_reg[k-1];
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign ai = a_reg[k-1];
        end

        assign xs   = xi >>> k;
        assign ys   = yi >>> k;
        assign ypos = !yi[swc_pkg::VW-1] && (yi != '0);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ypos)
                begin
                    x_reg[k] <= xi + ys;
                    y_reg[k] <= yi - xs;
                    a_reg[k] <= ai + swc_pkg::ATAN_BAU[k];
                end
                else
                begin
                    x_reg[k] <= xi - ys;
                    y_reg[k] <= yi + xs;
                    a_reg[k] <= ai - swc_pkg::ATAN_BAU[k];
                end
            end
        end
    end

    assign out_vld = v_reg[N-1];
    assign x_out   = x_reg[N-1];
    assign ang_out = a_reg[N-1];

endmodule

`default_nettype wire

// ===== hw/rtl/swc_scale.sv =====
// ----------------------------------------------------------------------------
// swc_scale - radius gain removal, zoom, twist phase and rotation set-up
// Five register stages; the first four each hold one multiplier layer.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_scale (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_vld,
    input  wire logic signed [swc_pkg::VW-1:0]  mag_in,
    input  wire logic        [31:0]             ang_in,
    input  wire logic        [15:0]             zoom,
    input  wire logic signed [21:0]             twist,
    output logic                                out_vld,
    output logic signed [swc_pkg::RW-1:0]       x_out,
    output logic signed [swc_pkg::ZW-1:0]       z_out
);

    logic [4:0]  v_reg;
    logic [31:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic [31:0] rad_reg;        // true radius, Q.16
    logic [35:0] rz_reg;         // zoomed radius, Q.16
    logic signed [49:0] p_reg;   // twist * zoomed radius
    logic [41:0] glo_reg, ghi_reg;
    logic [53:0] phl_reg;
    logic [27:0] phh_reg;
    logic [35:0] x0_reg;
    logic signed [swc_pkg::RW-1:0] x_reg;
    logic signed [swc_pkg::ZW-1:0] z_reg;

    logic [32:0] mag_u;
    logic [56:0] m1;
    logic [47:0] m2;
    logic signed [55:0] p_ext;
    logic [59:0] gsum;
    logic [55:0] phase;
    logic [31:0] ang2;
    logic [31:0] ang_f;
    logic        back;

    assign mag_u = mag_in[swc_pkg::VW-1] ? 33'd0 : mag_in[32:0];
    assign m1    = mag_u * swc_pkg::INV_GAIN;
    assign m2    = rad_reg * zoom;
    assign p_ext = 56'(p_reg);
    assign gsum  = {ghi_reg, 18'd0} + {18'd0, glo_reg};
    assign phase = phl_reg[53:0] + {phh_reg, 28'd0};
    assign ang2  = a4_reg + phase[55:24];
    assign back  = (ang2[31:30] == 2'b01) || (ang2[31:30] == 2'b10);
    assign ang_f = back ? (ang2 - swc_pkg::HALF_TURN) : ang2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= m1[55:24];
            a1_reg  <= ang_in;

            rz_reg  <= m2[47:12];
            a2_reg  <= a1_reg;

            p_reg   <= twist * $signed({1'b0, rz_reg[35:8]});
            glo_reg <= rz_reg[17:0] * swc_pkg::INV_GAIN;
            ghi_reg <= rz_reg[35:18] * swc_pkg::INV_GAIN;
            a3_reg  <= a2_reg;

            phl_reg <= p_ext[27:0] * swc_pkg::TWIST_TO_BAU;
            phh_reg <= 28'(p_ext[55:28] * swc_pkg::TWIST_TO_BAU);
            x0_reg  <= gsum[59:24];
            a4_reg  <= a3_reg;

            x_reg   <= back ? -$signed({4'd0, x0_reg}) : $signed({4'd0, x0_reg});
            z_reg   <= swc_pkg::ZW'($signed(ang_f));
        end
    end

    assign out_vld = v_reg[4];
    assign x_out   = x_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swc_rotation.sv =====
// ----------------------------------------------------------------------------
// swc_rotation - pipelined CORDIC in rotation mode
// One micro-rotation per register stage; drives the residual angle to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_rotation (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_vld,
    input  wire logic signed [swc_pkg::RW-1:0]  x_in,
    input  wire logic signed [swc_pkg::ZW-1:0]  z_in,
    output logic                                out_vld,
    output logic signed [swc_pkg::RW-1:0]       x_out,
    output logic signed [swc_pkg::RW-1:0]       y_out
);

    localparam int N = swc_pkg::NSTG;

    logic                          v_reg [N];
    logic signed [swc_pkg::RW-1:0] x_reg [N];
    logic signed [swc_pkg::RW-1:0] y_reg [N];
    logic signed [swc_pkg::ZW-1:0] z_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stg
        logic                          vi;
        logic signed [swc_pkg::RW-1:0] xi;
        logic signed [swc_pkg::RW-1:0] yi;
        logic signed [swc_pkg::ZW-1:0] zi;
        logic signed [swc_pkg::RW-1:0] xs;
        logic signed [swc_pkg::RW-1:0] ys;
        logic signed [swc_pkg::ZW-1:0] at;

        if (k == 0) begin : g_first
            assign vi = in_vld;
            assign xi = x_in;
            assign yi = '0;
            assign zi = z_in;
        end
        else begin : g_rest
            assign vi = v_reg[k-1];
            assign xi = x_reg[k-1];
            assign yi = y_reg[k-1];
            assign zi = z_reg[k-1];
        end

        assign xs = xi >>> k;
        assign ys = yi >>> k;
        assign at = $signed({2'b00, swc_pkg::ATAN_BAU[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[swc_pkg::ZW-1])
                begin
                    x_reg[k] <= xi - ys;
                    y_reg[k] <= yi + xs;
                    z_reg[k] <= zi - at;
                end
                else
                begin
                    x_reg[k] <= xi + ys;
                    y_reg[k] <= yi - xs;
                    z_reg[k] <= zi + at;
                end
            end
        end
    end

    assign out_vld = v_reg[N-1];
    assign x_out   = x_reg[N-1];
    assign y_out   = y_reg[N-1];

endmodule

`default_nettype wire
